>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/ips32_pkg.sv
// Shared types and codes for the IPS32 patch stream parser.
package ips32_pkg;

  typedef struct packed {
    logic [7:0] patch_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [15:0] length;
    logic [7:0]  data;
    logic [1:0]  error_code;
    logic        beyond_end;
  } out_item_t;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_SHORT  = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_FOOTER = 2'd2;

  // Header and footer characters
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_F     = 8'h46;

  // Shortest legal stream: header plus footer
  localparam logic [3:0] MIN_STREAM = 4'd9;

endpackage

>>> rtl/ips32_parse_core.sv
// Per-byte IPS32 record parser: stream state and the result of one request.
module ips32_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ips32_pkg::in_item_t item,
  input  logic [31:0]         output_size,
  output logic                res_valid,
  output ips32_pkg::out_item_t res
);
  import ips32_pkg::*;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_BADHDR   = 3'd1;
  localparam logic [2:0] PH_OFFSET   = 3'd2;
  localparam logic [2:0] PH_SIZE     = 3'd3;
  localparam logic [2:0] PH_LITERAL  = 3'd4;
  localparam logic [2:0] PH_RUNCOUNT = 3'd5;
  localparam logic [2:0] PH_RUNVALUE = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  fbi_r, fbi_nxt;
  logic [31:0] ro_r, ro_nxt;
  logic [15:0] rs_r, rs_nxt;
  logic [31:0] wa_r, wa_nxt;
  logic [3:0]  bs_r, bs_nxt;
  logic [2:0]  fm_r, fm_nxt;

  logic [7:0]  b;
  logic [7:0]  hdr_char;
  logic [7:0]  ftr_char;
  logic [2:0]  fm_base;
  logic [15:0] rs_shift;
  logic [15:0] rs_dec;
  logic [32:0] fill_reach;
  logic        done;

  assign b          = item.patch_byte;
  assign rs_shift   = {rs_r[7:0], b};
  assign rs_dec     = rs_r - 16'd1;
  assign fill_reach = {1'b0, ro_r} + {17'd0, rs_r};
  assign fm_base    = (fbi_r == 3'd0) ? 3'd0 : fm_r;
  assign done       = (phase_r == PH_OFFSET) && (fbi_r == 3'd3) && (fm_r == 3'd3) &&
                      (b == CH_F);

  // Expected header character at this position
  always_comb begin
    case (fbi_r)
      3'd0:    hdr_char = CH_I;
      3'd1:    hdr_char = CH_P;
      3'd2:    hdr_char = CH_S;
      3'd3:    hdr_char = CH_3;
      3'd4:    hdr_char = CH_2;
      default: hdr_char = 8'h00;
    endcase
  end

  // Expected footer character at this offset byte
  always_comb begin
    case (fbi_r[1:0])
      2'd0:    ftr_char = CH_E;
      2'd1:    ftr_char = CH_E;
      2'd2:    ftr_char = CH_O;
      default: ftr_char = CH_F;
    endcase
  end

  // Parse one byte: next state and optional result
  always_comb begin
    phase_nxt = phase_r;
    fbi_nxt   = fbi_r;
    ro_nxt    = ro_r;
    rs_nxt    = rs_r;
    wa_nxt    = wa_r;
    fm_nxt    = fm_r;
    bs_nxt    = (bs_r < MIN_STREAM) ? bs_r + 4'd1 : bs_r;
    res_valid = 1'b0;
    res       = '0;

    if (item.is_last) begin
      // End of stream: report and clear for the next one
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
      if (bs_nxt < MIN_STREAM) begin
        res.error_code = ERR_SHORT;
      end else if (phase_r == PH_HEADER || phase_r == PH_BADHDR) begin
        res.error_code = ERR_HEADER;
      end else if (done) begin
        res.kind = KIND_DONE;
      end else begin
        res.error_code = ERR_FOOTER;
      end
      phase_nxt = PH_HEADER;
      fbi_nxt   = 3'd0;
      ro_nxt    = '0;
      rs_nxt    = '0;
      wa_nxt    = '0;
      bs_nxt    = '0;
      fm_nxt    = '0;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (fbi_r > 3'd4 || b != hdr_char) begin
            phase_nxt = PH_BADHDR;
          end else if (fbi_r == 3'd4) begin
            phase_nxt = PH_OFFSET;
            fbi_nxt   = 3'd0;
            fm_nxt    = 3'd0;
          end else begin
            fbi_nxt = fbi_r + 3'd1;
          end
        end
        PH_BADHDR: begin
          // swallow bytes until the final one
        end
        PH_OFFSET: begin
          fm_nxt = (fm_base == fbi_r && b == ftr_char) ? fm_base + 3'd1 : fm_base;
          ro_nxt = {ro_r[23:0], b};
          if (fbi_r >= 3'd3) begin
            phase_nxt = PH_SIZE;
            fbi_nxt   = 3'd0;
            rs_nxt    = '0;
          end else begin
            fbi_nxt = fbi_r + 3'd1;
          end
        end
        PH_SIZE: begin
          rs_nxt = rs_shift;
          if (fbi_r >= 3'd1) begin
            fbi_nxt = 3'd0;
            if (rs_shift != 16'd0) begin
              phase_nxt = PH_LITERAL;
              wa_nxt    = ro_r;
            end else begin
              phase_nxt = PH_RUNCOUNT;
            end
          end else begin
            fbi_nxt = fbi_r + 3'd1;
          end
        end
        PH_LITERAL: begin
          res_valid      = 1'b1;
          res.kind       = KIND_WRITE;
          res.address    = wa_r;
          res.length     = 16'd1;
          res.data       = b;
          res.beyond_end = (wa_r >= output_size) || (wa_r < ro_r);
          wa_nxt         = wa_r + 32'd1;
          rs_nxt         = rs_dec;
          if (rs_dec == 16'd0) begin
            phase_nxt = PH_OFFSET;
            fbi_nxt   = 3'd0;
            fm_nxt    = 3'd0;
          end
        end
        PH_RUNCOUNT: begin
          rs_nxt = rs_shift;
          if (fbi_r >= 3'd1) begin
            fbi_nxt   = 3'd0;
            phase_nxt = PH_RUNVALUE;
          end else begin
            fbi_nxt = fbi_r + 3'd1;
          end
        end
        PH_RUNVALUE: begin
          if (rs_r != 16'd0) begin
            res_valid      = 1'b1;
            res.kind       = KIND_FILL;
            res.address    = ro_r;
            res.length     = rs_r;
            res.data       = b;
            res.beyond_end = fill_reach > {1'b0, output_size};
          end
          phase_nxt = PH_OFFSET;
          fbi_nxt   = 3'd0;
          fm_nxt    = 3'd0;
        end
        default: begin
          phase_nxt = PH_BADHDR;
        end
      endcase
    end
  end

  // Advance stream state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fbi_r   <= '0;
      ro_r    <= '0;
      rs_r    <= '0;
      wa_r    <= '0;
      bs_r    <= '0;
      fm_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fbi_r   <= fbi_nxt;
      ro_r    <= ro_nxt;
      rs_r    <= rs_nxt;
      wa_r    <= wa_nxt;
      bs_r    <= bs_nxt;
      fm_r    <= fm_nxt;
    end
  end

endmodule

>>> rtl/ips32_patch_stream_parser.sv
// IPS32 patch stream parser: takes patch bytes, gives at most one result for each byte.
// A result is registered in out_r, or in the skid register skid_r while the output stalls.
// Throughput: one byte per cycle while in_ready; the parse is a single pass from byte to result.
// A two-entry output stage (result register plus skid) takes one more request while out
// stalls; in_ready drops only while the skid holds a result.
// Reset (rst_n, synchronous, low): parser to header phase, output empty, output_size all ones.
`include "assert_macros.svh"

module ips32_patch_stream_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ips32_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ips32_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);
  import ips32_pkg::*;

  logic [31:0] output_size_r;
  logic        out_valid_r;
  out_item_t   out_r;
  logic        skid_valid_r;
  out_item_t   skid_r;
  logic        accept;
  logic        res_valid;
  out_item_t   res;
  logic        push;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign push      = accept && res_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Hold the output size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_size_r <= 32'hFFFF_FFFF;
    end else if (cfg_wr_en) begin
      output_size_r <= cfg_wr_data;
    end
  end

  ips32_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .output_size (output_size_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register with skid: drain skid first, else load the new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  `ASSERT_NEVER(a_skid_without_out, clk, rst_n,
                skid_valid_r && !out_valid_r, "skid full with output empty")
  `ASSERT_AT(a_stall_only_on_backpressure, clk, rst_n,
             !in_ready |-> $past(out_valid_r && !out_ready),
             "input stalled without output backpressure")
  `ASSERT_AT(a_status_fields_clear, clk, rst_n,
             (out_valid && (out_item.kind == KIND_DONE || out_item.kind == KIND_ERROR)) |->
             (out_item.address == 32'd0 && out_item.length == 16'd0 &&
              out_item.beyond_end == 1'b0),
             "done or error carries write fields")

endmodule
